FILE: hw/rtl/rqh_pkg.sv
`timescale 1ns / 1ps

package rqh_pkg;

  // fixed field widths
  localparam int REQ_W       = 2;
  localparam int QUAL_W      = 7;
  localparam int IDX_W       = 7;
  localparam int MEAN_W      = 7;
  localparam int BIN_COUNT_W = 32;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_QUAL  = 2'd0,
    REQ_END   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD
  } rqh_state_t;

endpackage

FILE: hw/rtl/rqh_in_if.sv
`timescale 1ns / 1ps

interface rqh_in_if import rqh_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [QUAL_W-1:0] quality_byte;
  logic [IDX_W-1:0]  bin_index;

  modport source (output valid, output req_type, output quality_byte, output bin_index,
                  input ready);
  modport sink (input valid, input req_type, input quality_byte, input bin_index,
                output ready);

endinterface

FILE: hw/rtl/rqh_out_if.sv
`timescale 1ns / 1ps

interface rqh_out_if import rqh_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [MEAN_W-1:0]      mean_quality;
  logic [BIN_COUNT_W-1:0] bin_count;
  logic                   read_too_long;

  modport source (output valid, output mean_quality, output bin_count,
                  output read_too_long, input ready);
  modport sink (input valid, input mean_quality, input bin_count, input read_too_long,
                output ready);

endinterface

FILE: hw/rtl/rqh_ram.sv
`timescale 1ns / 1ps

module rqh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/rqh_div.sv
`timescale 1ns / 1ps

module rqh_div import rqh_pkg::*; #(
  parameter int SUM_W = 23,
  parameter int CNT_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [MEAN_W-1:0] quotient
);

  localparam int STEP_W = $clog2(MEAN_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [MEAN_W-1:0] quot_r, quot_nxt;
  logic [SUM_W-1:0]  den_shift;
  logic              fits;

  // one restoring step per cycle, quotient bit from the top down;
  // the quotient of a byte mean never exceeds the byte range
  assign den_shift = SUM_W'(den_r) << step_r;
  assign fits      = rem_r >= den_shift;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(MEAN_W - 1);
      rem_nxt  = dividend;
      den_nxt  = divisor;
      quot_nxt = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - den_shift;
        quot_nxt[step_r] = 1'b1;
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

  // a new division is never started over a running one
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  // completion follows the last step only
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a running division");

endmodule

FILE: hw/rtl/read_mean_quality_histogram.sv
`timescale 1ns / 1ps

// channel   dir  handshake     payload
// in_ch     in   valid/ready   req_type[1:0], quality_byte[6:0], bin_index[6:0]
// out_ch    out  valid/ready   mean_quality[6:0], bin_count[31:0], read_too_long
//
// quality byte and clear histogram: taken back to back, the sequencer stays idle
// read bin and empty read: ram read, then output register once the output slot is free
// end of read: seven steps of the bit-serial divider, then ram read and output register
// reset (rst_n low, synchronous) zeroes the read totals and marks every bin empty
// a finished result waits in the output register; a later result waits for it to go

module read_mean_quality_histogram import rqh_pkg::*; #(
  parameter int MAX_READ_LEN = 65535,
  parameter int NUM_BINS     = 128,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  rqh_in_if.sink   in_ch,
  rqh_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_READ_LEN + 1);
  localparam int SUM_W = CNT_W + QUAL_W;
  localparam int AW    = $clog2(NUM_BINS);

  rqh_state_t             state_r, state_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   long_r, long_nxt;
  logic                   is_end_r, is_end_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [NUM_BINS-1:0]    bin_vld_r, bin_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [MEAN_W-1:0]      out_mean_r, out_mean_nxt;
  logic [BIN_COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                   out_long_r, out_long_nxt;

  logic                   in_ready;
  logic                   slot_free;
  logic                   div_start;
  logic                   div_done;
  logic [MEAN_W-1:0]      div_quot;
  logic                   ram_rd_en;
  logic [AW-1:0]          ram_rd_addr;
  logic                   ram_wr_en;
  logic [COUNT_WIDTH-1:0] ram_rd_data;
  logic [COUNT_WIDTH-1:0] bin_cur;
  logic [COUNT_WIDTH-1:0] bin_inc;

  // divider for the read mean
  rqh_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // histogram counters
  rqh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (addr_r),
    .wr_data (bin_inc),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // bin value, empty bins read as zero; saturating increment
  assign bin_cur   = bin_vld_r[addr_r] ? ram_rd_data : '0;
  assign bin_inc   = (bin_cur == '1) ? bin_cur : bin_cur + COUNT_WIDTH'(1);
  assign slot_free = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    long_nxt      = long_r;
    is_end_nxt    = is_end_r;
    addr_nxt      = addr_r;
    bin_vld_nxt   = bin_vld_r;
    out_valid_nxt = out_valid_r;
    out_mean_nxt  = out_mean_r;
    out_count_nxt = out_count_r;
    out_long_nxt  = out_long_r;
    in_ready      = 1'b0;
    div_start     = 1'b0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = addr_r;
    ram_wr_en     = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          case (req_t'(in_ch.req_type))
            REQ_QUAL: begin
              if (cnt_r < CNT_W'(MAX_READ_LEN)) begin
                sum_nxt = sum_r + SUM_W'(in_ch.quality_byte);
                cnt_nxt = cnt_r + CNT_W'(1);
              end else begin
                long_nxt = 1'b1;
              end
            end
            REQ_END: begin
              is_end_nxt = 1'b1;
              if (cnt_r == '0) begin
                // empty read lands in bin zero
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                addr_nxt    = '0;
                state_nxt   = ST_UPD;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            REQ_READ: begin
              is_end_nxt  = 1'b0;
              ram_rd_en   = 1'b1;
              ram_rd_addr = AW'(in_ch.bin_index);
              addr_nxt    = AW'(in_ch.bin_index);
              state_nxt   = ST_UPD;
            end
            REQ_CLEAR: begin
              bin_vld_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(div_quot);
          addr_nxt    = AW'(div_quot);
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = MEAN_W'(addr_r);
          if (is_end_r) begin
            out_count_nxt         = BIN_COUNT_W'(bin_inc);
            out_long_nxt          = long_r;
            ram_wr_en             = 1'b1;
            bin_vld_nxt[addr_r]   = 1'b1;
            sum_nxt               = '0;
            cnt_nxt               = '0;
            long_nxt              = 1'b0;
          end else begin
            out_count_nxt = BIN_COUNT_W'(bin_cur);
            out_long_nxt  = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      long_r      <= 1'b0;
      bin_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      long_r      <= long_nxt;
      bin_vld_r   <= bin_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    is_end_r    <= is_end_nxt;
    addr_r      <= addr_nxt;
    out_mean_r  <= out_mean_nxt;
    out_count_r <= out_count_nxt;
    out_long_r  <= out_long_nxt;
  end

  // channel drive
  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.mean_quality  = out_mean_r;
  assign out_ch.bin_count     = out_count_r;
  assign out_ch.read_too_long = out_long_r;

  // byte count never passes the read length limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_READ_LEN))
    else $error("byte count beyond read length limit");

  // divider completes only while the sequencer waits for it
  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider done outside its wait state");

  // a finished read leaves a result and clean read totals
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && slot_free && is_end_r) |=>
      (cnt_r == '0 && sum_r == '0 && !long_r && out_valid_r))
    else $error("end of read left stale totals or no result");

  // a result-bearing transfer always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready &&
     (in_ch.req_type == REQ_END || in_ch.req_type == REQ_READ)) |=> state_r != ST_IDLE)
    else $error("result request did not start work");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb import rqh_pkg::*; ();

  localparam int READ_LEN_MAX = 65535;
  localparam int BIN_TOTAL    = 128;
  localparam int CNT_W        = 32;
  localparam int RAND_ITEMS   = 1750;
  localparam int TAIL_ITEMS   = 200;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    req_t              kind;
    logic [QUAL_W-1:0] qual;
    logic [IDX_W-1:0]  idx;
    bit                drain_first;
  } req_item_t;

  typedef struct {
    logic [MEAN_W-1:0]      mean;
    logic [BIN_COUNT_W-1:0] count;
    logic                   too_long;
  } hist_result_t;

  logic clk = 1'b0;
  logic rst_n;

  rqh_in_if  in_ch ();
  rqh_out_if out_ch ();

  read_mean_quality_histogram #(
    .MAX_READ_LEN (READ_LEN_MAX),
    .NUM_BINS     (BIN_TOTAL),
    .COUNT_WIDTH  (CNT_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [22:0]            read_sum;
  logic [15:0]            read_len;
  logic                   read_dropped;
  logic [BIN_COUNT_W-1:0] bin_model [BIN_TOTAL];

  req_item_t    req_backlog [$];
  hist_result_t due_results [$];
  req_item_t    cur_req;
  hist_result_t got_res;
  hist_result_t want_res;

  bit in_busy;
  bit quiet_tail;
  int in_gap;
  int in_idle_pct;
  int reqs_sent;
  int out_gap;
  int out_idle_pct;
  int out_cycles;
  int stall_left;
  bit stall_done;
  int results_seen;
  int fails;
  int long_items;

  // model of one accepted request
  task automatic track_request(input req_item_t it);
    logic [22:0]      avg;
    logic [MEAN_W-1:0] bin;
    hist_result_t     r;
    case (it.kind)
      REQ_QUAL: begin
        if (read_len < READ_LEN_MAX) begin
          read_sum = read_sum + it.qual;
          read_len = read_len + 1'b1;
        end else begin
          read_dropped = 1'b1;
        end
      end
      REQ_END: begin
        avg = (read_len == 0) ? '0 : read_sum / read_len;
        bin = avg[MEAN_W-1:0];
        if (bin_model[bin] != '1) bin_model[bin] = bin_model[bin] + 1'b1;
        r.mean     = bin;
        r.count    = bin_model[bin];
        r.too_long = read_dropped;
        due_results.push_back(r);
        read_sum     = '0;
        read_len     = '0;
        read_dropped = 1'b0;
      end
      REQ_READ: begin
        r.mean     = it.idx;
        r.count    = bin_model[it.idx];
        r.too_long = 1'b0;
        due_results.push_back(r);
      end
      default: begin
        foreach (bin_model[i]) bin_model[i] = '0;
      end
    endcase
  endtask

  task automatic push_req(input req_t kind, input int q, input int i, input bit drain = 1'b0);
    req_item_t it;
    it.kind        = kind;
    it.qual        = q[QUAL_W-1:0];
    it.idx         = i[IDX_W-1:0];
    it.drain_first = drain;
    req_backlog.push_back(it);
  endtask

  // mostly phred+33 range, some full range, some extremes
  function automatic int rand_qual();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(33, 74);
    if (pick < 90) return $urandom_range(0, 127);
    return ($urandom_range(0, 1) != 0) ? 127 : 0;
  endfunction

  task automatic queue_read(input int len, input bit drain);
    for (int i = 0; i < len; i++) begin
      push_req(REQ_QUAL, rand_qual(), $urandom_range(0, 127), drain && (i == 0));
      // occasional clear in the middle of a read
      if ($urandom_range(0, 199) == 0) push_req(REQ_CLEAR, $urandom_range(0, 127),
                                                $urandom_range(0, 127));
    end
    push_req(REQ_END, $urandom_range(0, 127), $urandom_range(0, 127), drain && (len == 0));
  endtask

  // long read of fixed or random bytes, optionally past the length limit
  task automatic queue_long_read(input int len, input bit all_max);
    for (int i = 0; i < len; i++)
      push_req(REQ_QUAL, all_max ? 127 : $urandom_range(0, 127), $urandom_range(0, 127));
    push_req(REQ_END, 0, 0);
    long_items += len + 1;
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (req_backlog.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (req_backlog[0].drain_first && due_results.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < in_idle_pct) begin
        in_gap = $urandom_range(0, 10);
        in_ch.valid <= 1'b0;
      end else begin
        cur_req = req_backlog.pop_front();
        in_ch.req_type     <= cur_req.kind;
        in_ch.quality_byte <= cur_req.qual;
        in_ch.bin_index    <= cur_req.idx;
        in_ch.valid        <= 1'b1;
        in_busy = 1'b1;
        reqs_sent++;
        if (reqs_sent % 256 == 0) begin
          case ($urandom_range(0, 2))
            0: in_idle_pct = 0;
            1: in_idle_pct = 12;
            default: in_idle_pct = 35;
          endcase
        end
      end
    end
    quiet_tail = req_backlog.size() <= TAIL_ITEMS;
  end

  // request transfer
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      track_request(cur_req);
      in_busy = 1'b0;
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_cycles++;
      if (out_cycles % 500 == 0) begin
        case ($urandom_range(0, 2))
          0: out_idle_pct = 0;
          1: out_idle_pct = 12;
          default: out_idle_pct = 35;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!stall_done && results_seen >= 100) begin
        stall_done = 1'b1;
        stall_left = 399;
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_res.mean     = out_ch.mean_quality;
      got_res.count    = out_ch.bin_count;
      got_res.too_long = out_ch.read_too_long;
      if (due_results.size() == 0) begin
        $error("unexpected result: mean_quality %0d bin_count %0d read_too_long %0b",
               got_res.mean, got_res.count, got_res.too_long);
        fails++;
      end else begin
        want_res = due_results.pop_front();
        if (got_res.mean !== want_res.mean) begin
          $error("mean_quality: expected %0d, got %0d", want_res.mean, got_res.mean);
          fails++;
        end
        if (got_res.count !== want_res.count) begin
          $error("bin_count: expected %0d, got %0d", want_res.count, got_res.count);
          fails++;
        end
        if (got_res.too_long !== want_res.too_long) begin
          $error("read_too_long: expected %0b, got %0b", want_res.too_long, got_res.too_long);
          fails++;
        end
      end
      results_seen++;
    end
  end

  // watchdog
  initial begin
    #500_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    int len;
    int dir_items;
    int reads_done;
    bit longs_queued;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_QUAL;
    in_ch.quality_byte = '0;
    in_ch.bin_index    = '0;
    out_ch.ready       = 1'b0;
    read_sum           = '0;
    read_len           = '0;
    read_dropped       = 1'b0;
    foreach (bin_model[i]) bin_model[i] = '0;
    in_busy      = 1'b0;
    in_gap       = 0;
    in_idle_pct  = 12;
    out_gap      = 0;
    out_idle_pct = 12;
    stall_left   = 0;
    stall_done   = 1'b0;
    fails        = 0;
    long_items   = 0;
    longs_queued = 1'b0;
    reads_done   = 0;

    // directed: empty bins, empty read, extremes, truncation
    push_req(REQ_READ, 0, 0);
    push_req(REQ_READ, 127, 127);
    push_req(REQ_END, 0, 0);
    push_req(REQ_QUAL, 0, 127);
    push_req(REQ_END, 127, 127);
    push_req(REQ_QUAL, 127, 0);
    push_req(REQ_QUAL, 127, 0);
    push_req(REQ_END, 0, 0);
    push_req(REQ_QUAL, 127, 0);
    push_req(REQ_QUAL, 0, 0);
    push_req(REQ_END, 0, 0);
    push_req(REQ_QUAL, 1, 0);
    push_req(REQ_QUAL, 2, 0);
    push_req(REQ_END, 0, 0);
    push_req(REQ_READ, 0, 127);
    push_req(REQ_READ, 0, 63);
    // clear keeps the read in progress
    push_req(REQ_QUAL, 100, 0);
    push_req(REQ_CLEAR, 0, 0);
    push_req(REQ_QUAL, 50, 0);
    push_req(REQ_END, 0, 0);
    push_req(REQ_READ, 0, 0);
    push_req(REQ_READ, 0, 75);
    push_req(REQ_CLEAR, 127, 127);
    push_req(REQ_READ, 0, 75);
    dir_items = req_backlog.size();

    // random reads with bin lookups, clears and noise
    while (req_backlog.size() - long_items < dir_items + RAND_ITEMS) begin
      if (!longs_queued && req_backlog.size() > 600) begin
        // at the limit with maximum sum, then past it
        queue_long_read(READ_LEN_MAX, 1'b1);
        push_req(REQ_READ, 0, 127);
        queue_long_read(READ_LEN_MAX + 2, 1'b0);
        long_items++;
        longs_queued = 1'b1;
      end
      case ($urandom_range(0, 99)) inside
        [0:9]:   len = 0;
        [10:14]: len = 1;
        [15:84]: len = $urandom_range(2, 30);
        default: len = $urandom_range(31, 200);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        push_req(req_t'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 127));
      end else begin
        queue_read(len, (reads_done % 25) == 24);
        reads_done++;
      end
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) != 0) push_req(REQ_READ, rand_qual(), $urandom_range(0, 127));
          else push_req(REQ_READ, rand_qual(), $urandom_range(30, 45));
        end
      end
      if ($urandom_range(0, 39) == 0) push_req(REQ_CLEAR, rand_qual(), $urandom_range(0, 127));
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || in_busy) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
